// ===== hw/rtl/edfrs_pkg.sv =====
// shared types and constants for the edf ready set selector
package edfrs_pkg;

   localparam int TASK_COUNT_DEF = 4;
   localparam int MODE_W         = 2;
   localparam int TASK_W         = 2;
   localparam int DL_W           = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_ENQ = 2'd0,
      MODE_REM = 2'd1,
      MODE_DEQ = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic enq_en;
      logic rem_mode;
      logic clr_en;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/edf_ready_set_selector.sv =====
// Earliest-deadline-first ready set: TASK_COUNT task cells in a row. Enqueue writes the
// addressed cell at accept and then, like the unused mode three, goes to the finish state,
// where its all-zero result is loaded once the output register is free. Remove and dequeue
// send a candidate (found, id, deadline) down the row one cell per cycle; each cell replaces
// it with itself when it is ready and earlier (dequeue) or addressed (remove). When the scan
// has passed every cell the last cell holds the winner, which is cleared while the result
// register is loaded. Items are handled one at a time; a new item is taken while the
// previous result still waits in the output register, and a finished item waits only if
// that register is still stalled.
module edf_ready_set_selector
   import edfrs_pkg::*;
#(
   parameter int TASK_COUNT = TASK_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [TASK_W-1:0] req_task_id,
   input  logic [DL_W-1:0]   req_deadline,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_found,
   output logic [TASK_W-1:0] rsp_chosen_task,
   output logic [DL_W-1:0]   rsp_chosen_deadline
);

   localparam int IDX_W = $clog2(TASK_COUNT);

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        cnt_ff, cnt_in;
   logic                    scan_ff, scan_in;
   logic                    rem_ff, rem_in;
   logic [TASK_COUNT-1:0]   hit_ff, hit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [TASK_W-1:0]       rsp_task_ff, rsp_task_in;
   logic [DL_W-1:0]         rsp_dl_ff, rsp_dl_in;

   logic                    accept;
   logic                    out_free;
   logic                    scan_done;
   logic                    win_have;
   logic [IDX_W-1:0]        win_id;
   logic [DL_W-1:0]         win_dl;
   logic [TASK_COUNT-1:0]   hit_now;
   logic [TASK_COUNT-1:0]   sel_vec;
   cell_ctrl_type           ctrl;

   logic                    cand_have [0:TASK_COUNT];
   logic [IDX_W-1:0]        cand_id   [0:TASK_COUNT];
   logic [DL_W-1:0]         cand_dl   [0:TASK_COUNT];

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_done = (cnt_ff == IDX_W'(TASK_COUNT - 1));

   // ids at or beyond TASK_COUNT hit no cell
   for (genvar i = 0; i < TASK_COUNT; i++) begin : g_hit
      assign hit_now[i] = (int'(req_task_id) == i);
   end

   assign cand_have[0] = 1'b0;
   assign cand_id[0]   = '0;
   assign cand_dl[0]   = '0;

   for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
      edfrs_cell #(
         .IDX_W   (IDX_W),
         .CELL_ID (i)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .sel            (sel_vec[i]),
         .enq_deadline   (req_deadline),
         .win_id         (win_id),
         .cand_have_prev (cand_have[i]),
         .cand_id_prev   (cand_id[i]),
         .cand_dl_prev   (cand_dl[i]),
         .cand_have_next (cand_have[i+1]),
         .cand_id_next   (cand_id[i+1]),
         .cand_dl_next   (cand_dl[i+1])
      );
   end

   assign win_have = cand_have[TASK_COUNT];
   assign win_id   = cand_id[TASK_COUNT];
   assign win_dl   = cand_dl[TASK_COUNT];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_REM || req_mode == MODE_DEQ) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_stall     = 1'b1;
      ctrl.enq_en   = 1'b0;
      ctrl.rem_mode = rem_ff;
      ctrl.clr_en   = 1'b0;
      sel_vec       = hit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            ctrl.enq_en = accept && (req_mode == MODE_ENQ);
            sel_vec     = hit_now;
         end
         ST_SCAN: begin
         end
         ST_FINISH: begin
            ctrl.clr_en = out_free && scan_ff && win_have;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      scan_in      = scan_ff;
      rem_in       = rem_ff;
      hit_in       = hit_ff;
      cnt_in       = '0;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_task_in  = rsp_task_ff;
      rsp_dl_in    = rsp_dl_ff;
      if (accept) begin
         scan_in = (req_mode == MODE_REM) || (req_mode == MODE_DEQ);
         rem_in  = (req_mode == MODE_REM);
         hit_in  = hit_now;
      end
      if (state_ff == ST_SCAN) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = scan_ff && win_have;
         rsp_task_in  = (scan_ff && win_have) ? TASK_W'(win_id) : '0;
         rsp_dl_in    = (scan_ff && win_have) ? win_dl : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      rem_ff       <= rem_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_dl_ff    <= rsp_dl_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_chosen_task     = rsp_task_ff;
   assign rsp_chosen_deadline = rsp_dl_ff;

endmodule

// ===== hw/rtl/edfrs_cell.sv =====
// one task slot: ready mark, deadline and one stage of the candidate chain
module edfrs_cell
   import edfrs_pkg::*;
#(
   parameter int IDX_W   = 2,
   parameter int CELL_ID = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic              sel,
   input  logic [DL_W-1:0]   enq_deadline,
   input  logic [IDX_W-1:0]  win_id,
   input  logic              cand_have_prev,
   input  logic [IDX_W-1:0]  cand_id_prev,
   input  logic [DL_W-1:0]   cand_dl_prev,
   output logic              cand_have_next,
   output logic [IDX_W-1:0]  cand_id_next,
   output logic [DL_W-1:0]   cand_dl_next
);

   logic              ready_ff, ready_in;
   logic [DL_W-1:0]   deadline_ff, deadline_in;
   logic              cand_have_ff, cand_have_in;
   logic [IDX_W-1:0]  cand_id_ff, cand_id_in;
   logic [DL_W-1:0]   cand_dl_ff, cand_dl_in;
   logic              take;
   logic              clr_hit;

   assign clr_hit = ctrl.clr_en && (win_id == IDX_W'(CELL_ID));

   // strict compare: an earlier cell keeps the slot on equal deadlines
   assign take = ready_ff &&
                 (ctrl.rem_mode ? sel : (!cand_have_prev || deadline_ff < cand_dl_prev));

   always_comb begin
      ready_in    = ready_ff;
      deadline_in = deadline_ff;
      if (ctrl.enq_en && sel) begin
         ready_in    = 1'b1;
         deadline_in = enq_deadline;
      end else if (clr_hit) begin
         ready_in = 1'b0;
      end
      if (take) begin
         cand_have_in = 1'b1;
         cand_id_in   = IDX_W'(CELL_ID);
         cand_dl_in   = deadline_ff;
      end else begin
         cand_have_in = cand_have_prev;
         cand_id_in   = cand_id_prev;
         cand_dl_in   = cand_dl_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= 1'b0;
         cand_have_ff <= 1'b0;
      end else begin
         ready_ff     <= ready_in;
         cand_have_ff <= cand_have_in;
      end
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      cand_id_ff  <= cand_id_in;
      cand_dl_ff  <= cand_dl_in;
   end

   assign cand_have_next = cand_have_ff;
   assign cand_id_next   = cand_id_ff;
   assign cand_dl_next   = cand_dl_ff;

endmodule

// ===== hw/rtl/edfrs_checker.sv =====
// port-level checks for the edf ready set selector, bound to the top level
module edfrs_checker
   import edfrs_pkg::*;
#(
   parameter int TASK_COUNT = TASK_COUNT_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [MODE_W-1:0] req_mode,
   input logic [TASK_W-1:0] req_task_id,
   input logic [DL_W-1:0]   req_deadline,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_found,
   input logic [TASK_W-1:0] rsp_chosen_task,
   input logic [DL_W-1:0]   rsp_chosen_deadline
);

   // a stalled request item holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_mode)
         && $stable(req_task_id) && $stable(req_deadline))
      else $error("request item changed while stalled");

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_chosen_task) && $stable(rsp_chosen_deadline))
      else $error("result item changed while stalled");

   // a miss carries an all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_chosen_task == '0 && rsp_chosen_deadline == '0)
      else $error("not-found result with nonzero payload");

   // one item at a time: the input stalls right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled while an item is in work");

   // a hit names an existing task
   a_task_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> int'(rsp_chosen_task) < TASK_COUNT)
      else $error("chosen task beyond task count");

endmodule

bind edf_ready_set_selector edfrs_checker #(.TASK_COUNT(TASK_COUNT)) u_edfrs_checker (.*);

// ===== dv/edf_ready_set_selector_checker.sv =====
// checker for the edf ready set selector: predicts every result and compares it
`timescale 1ns / 100ps

module edf_ready_set_selector_checker
   import edfrs_pkg::*;
#(
   parameter int TASK_COUNT = TASK_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [TASK_W-1:0] req_task_id,
   input  logic [DL_W-1:0]   req_deadline,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_found,
   input  logic [TASK_W-1:0] rsp_chosen_task,
   input  logic [DL_W-1:0]   rsp_chosen_deadline,
   output int                mismatches,
   output int                outstanding,
   output int                results_seen,
   output int                hits_seen
);

   typedef struct packed {
      logic              found;
      logic [TASK_W-1:0] chosen_id;
      logic [DL_W-1:0]   chosen_dl;
   } pick_type;

   logic            is_ready [TASK_COUNT];
   logic [DL_W-1:0] due_at   [TASK_COUNT];
   pick_type        expected_picks [$];

   initial begin
      mismatches   = 0;
      outstanding  = 0;
      results_seen = 0;
      hits_seen    = 0;
      foreach (due_at[i]) due_at[i] = '0;
      foreach (is_ready[i]) is_ready[i] = 1'b0;
   end

   // updates the ready set for one request and returns the pick it reports
   function automatic pick_type schedule_pick(logic [MODE_W-1:0] mode, logic [TASK_W-1:0] id,
                                             logic [DL_W-1:0] dl);
      pick_type res;
      logic     have;
      int       best;
      res  = '0;
      have = 1'b0;
      best = 0;
      case (mode)
         MODE_ENQ: begin
            if (int'(id) < TASK_COUNT) begin
               is_ready[id] = 1'b1;
               due_at[id]   = dl;
            end
         end
         MODE_REM: begin
            if (int'(id) < TASK_COUNT && is_ready[id]) begin
               is_ready[id]  = 1'b0;
               res.found     = 1'b1;
               res.chosen_id = id;
               res.chosen_dl = due_at[id];
            end
         end
         MODE_DEQ: begin
            // strict compare in rising id order keeps the lower id on a tie
            for (int i = 0; i < TASK_COUNT; i++) begin
               if (is_ready[i] && (!have || due_at[i] < due_at[best])) begin
                  have = 1'b1;
                  best = i;
               end
            end
            if (have) begin
               is_ready[best] = 1'b0;
               res.found      = 1'b1;
               res.chosen_id  = TASK_W'(best);
               res.chosen_dl  = due_at[best];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      pick_type want;
      pick_type got;
      if (reset) begin
         foreach (is_ready[i]) is_ready[i] = 1'b0;
         expected_picks.delete();
      end else begin
         // results first: a result never belongs to an item accepted at the same edge
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_found, rsp_chosen_task, rsp_chosen_deadline};
            results_seen++;
            if (rsp_found) hits_seen++;
            if (expected_picks.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: found=%0d task=%0d deadline=%h",
                           got.found, got.chosen_id, got.chosen_dl);
               mismatches++;
            end else begin
               want = expected_picks.pop_front();
               if (got != want) begin
                  if (mismatches < 10)
                     $display({"result %0d wrong: expected found=%0d task=%0d deadline=%h, ",
                               "got found=%0d task=%0d deadline=%h"}, results_seen,
                              want.found, want.chosen_id, want.chosen_dl,
                              got.found, got.chosen_id, got.chosen_dl);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_picks.push_back(schedule_pick(req_mode, req_task_id, req_deadline));
      end
      outstanding = expected_picks.size();
   end

endmodule

// ===== dv/edf_ready_set_selector_tb.sv =====
// testbench top for the edf ready set selector: stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module edf_ready_set_selector_tb;
   import edfrs_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 750;
   localparam int LONG_HOLD    = 200;
   localparam int CYCLE_LIMIT  = 300000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [MODE_W-1:0] req_mode;
   logic [TASK_W-1:0] req_task_id;
   logic [DL_W-1:0]   req_deadline;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_found;
   logic [TASK_W-1:0] rsp_chosen_task;
   logic [DL_W-1:0]   rsp_chosen_deadline;

   int mismatches;
   int outstanding;
   int results_seen;
   int hits_seen;
   int cycle_count;
   int hold_requests;
   int mode_sent [4];

   edf_ready_set_selector dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_task_id         (req_task_id),
      .req_deadline        (req_deadline),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_found           (rsp_found),
      .rsp_chosen_task     (rsp_chosen_task),
      .rsp_chosen_deadline (rsp_chosen_deadline)
   );

   edf_ready_set_selector_checker pick_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_task_id         (req_task_id),
      .req_deadline        (req_deadline),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_found           (rsp_found),
      .rsp_chosen_task     (rsp_chosen_task),
      .rsp_chosen_deadline (rsp_chosen_deadline),
      .mismatches          (mismatches),
      .outstanding         (outstanding),
      .results_seen        (results_seen),
      .hits_seen           (hits_seen)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // called just after a falling edge; returns just after the falling edge past acceptance
   task automatic send_item(logic [MODE_W-1:0] mode, logic [TASK_W-1:0] id,
                            logic [DL_W-1:0] dl);
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_task_id  <= id;
      req_deadline <= dl;
      do @(posedge clock); while (req_stall);
      mode_sent[mode]++;
      @(negedge clock);
   endtask

   task automatic random_item();
      int                r;
      logic [MODE_W-1:0] mode;
      logic [DL_W-1:0]   dl;
      r = $urandom_range(0, 99);
      if (r < 40)      mode = MODE_ENQ;
      else if (r < 58) mode = MODE_REM;
      else if (r < 95) mode = MODE_DEQ;
      else             mode = MODE_SPARE;
      // narrow ranges make ties common, the rest spreads over the full width
      case ($urandom_range(0, 5))
         0:       dl = '0;
         1:       dl = '1;
         2:       dl = DL_W'($urandom_range(0, 7));
         3:       dl = 32'hFFFF_FFF0 + DL_W'($urandom_range(0, 15));
         default: dl = $urandom();
      endcase
      send_item(mode, TASK_W'($urandom_range(0, 3)), dl);
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   // receiver: stall pattern changes per segment, with an occasional long hold-off
   initial begin
      int seg_len;
      int style;
      int hold_served;
      hold_served = 0;
      rsp_stall   = 1'b0;
      forever begin
         seg_len = $urandom_range(8, 60);
         style   = $urandom_range(0, 3);
         for (int k = 0; k < seg_len; k++) begin
            @(negedge clock);
            if (hold_served != hold_requests) begin
               hold_served = hold_requests;
               rsp_stall <= 1'b1;
               repeat (LONG_HOLD - 1) @(negedge clock);
            end else begin
               case (style)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                  2:       rsp_stall <= 1'($urandom_range(0, 1));
                  default: rsp_stall <= (k % 3 != 0);
               endcase
            end
         end
      end
   end

   initial begin
      int sent;
      int burst;
      int burst_no;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = MODE_ENQ;
      req_task_id   = '0;
      req_deadline  = '0;
      hold_requests = 0;
      foreach (mode_sent[i]) mode_sent[i] = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty set, absent task, unused mode
      send_item(MODE_DEQ, 2'd1, 32'h1234_5678);
      send_item(MODE_REM, 2'd0, '0);
      send_item(MODE_SPARE, 2'd3, '1);
      // extremes, a tie between tasks one and two, and an update of task three
      send_item(MODE_ENQ, 2'd0, 32'hFFFF_FFFF);
      send_item(MODE_ENQ, 2'd1, 32'h0000_0000);
      send_item(MODE_ENQ, 2'd2, 32'h0000_0000);
      send_item(MODE_ENQ, 2'd3, 32'h7FFF_FFFF);
      send_item(MODE_ENQ, 2'd3, 32'h0000_0001);
      send_item(MODE_SPARE, 2'd0, 32'h0000_0000);
      send_item(MODE_DEQ, 2'd3, '0);
      send_item(MODE_DEQ, 2'd0, '0);
      send_item(MODE_DEQ, 2'd0, '0);
      send_item(MODE_REM, 2'd0, '0);
      send_item(MODE_REM, 2'd0, '0);
      send_item(MODE_DEQ, 2'd0, '0);
      // all four tied, then alternating bit patterns
      send_item(MODE_ENQ, 2'd3, 32'hAAAA_AAAA);
      send_item(MODE_ENQ, 2'd2, 32'hAAAA_AAAA);
      send_item(MODE_ENQ, 2'd1, 32'hAAAA_AAAA);
      send_item(MODE_ENQ, 2'd0, 32'hAAAA_AAAA);
      send_item(MODE_ENQ, 2'd0, 32'h5555_5555);
      send_item(MODE_REM, 2'd3, '0);
      send_item(MODE_DEQ, 2'd0, '0);
      send_item(MODE_DEQ, 2'd0, '0);
      send_item(MODE_DEQ, 2'd0, '0);
      send_item(MODE_DEQ, 2'd0, '0);
      drain();

      sent     = 0;
      burst_no = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            random_item();
            sent++;
         end
         burst_no++;
         // receiver holds off while items keep coming, so the input backs up
         if (burst_no == 10) begin
            hold_requests++;
            repeat (24) begin
               random_item();
               sent++;
            end
         end
         if (burst_no % 15 == 7)
            drain();
         else
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      end

      drain();
      repeat (4 * TASK_COUNT_DEF + 4) @(negedge clock);
      $display("requests sent: %0d enqueue, %0d remove, %0d dequeue, %0d unused mode",
               mode_sent[MODE_ENQ], mode_sent[MODE_REM], mode_sent[MODE_DEQ],
               mode_sent[MODE_SPARE]);
      $display("results checked: %0d, %0d with a task picked, %0d mismatches",
               results_seen, hits_seen, mismatches);
      if (mismatches == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
